@@ rtl/core/mini_mips_execute_step_assert.svh @@
// Assertion macros for the mini MIPS execute step.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef MINI_MIPS_EXECUTE_STEP_ASSERT_SVH
`define MINI_MIPS_EXECUTE_STEP_ASSERT_SVH

// Same-cycle implication.
`define MMES_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MMES_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mmes_pkg.sv @@
// Shared types, opcodes and widths for the mini MIPS execute step.
// No dependencies; used by every module of the block.
`default_nettype none

package mmes_pkg;

   localparam int OP_W        = 4;
   localparam int REG_IDX_W   = 5;
   localparam int REG_COUNT   = 32;
   localparam int WORD_W      = 32;
   localparam int PC_W        = 21;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = 3;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
   localparam logic [OP_W-1:0] OP_BEQ  = 4'd3;
   localparam logic [OP_W-1:0] OP_BNE  = 4'd4;
   localparam logic [OP_W-1:0] OP_SLT  = 4'd5;
   localparam logic [OP_W-1:0] OP_J    = 4'd6;
   localparam logic [OP_W-1:0] OP_LW   = 4'd7;
   localparam logic [OP_W-1:0] OP_SW   = 4'd8;
   localparam logic [OP_W-1:0] OP_ADDI = 4'd9;
   localparam logic [OP_W-1:0] OP_HALT = 4'd10;

   // request item, operation in the low bits
   typedef struct packed {
      logic [PC_W-1:0]      immediate;
      logic [REG_IDX_W-1:0] third_reg;
      logic [REG_IDX_W-1:0] second_reg;
      logic [REG_IDX_W-1:0] first_reg;
      logic [OP_W-1:0]      operation;
   } req_item_type;

   // response item, next_pc in the low bits
   typedef struct packed {
      logic                 address_error;
      logic                 halted;
      logic [WORD_W-1:0]    write_value;
      logic [REG_IDX_W-1:0] write_index;
      logic                 write_enable;
      logic [PC_W-1:0]      next_pc;
   } rsp_result_type;

   // execute stage outcome
   typedef struct packed {
      logic           mem_rd;
      logic           mem_wr;
      rsp_result_type res;
   } exec_ctl_type;

   // R-type ops read third_reg on the second port, the rest read first_reg
   function automatic logic uses_third(input logic [OP_W-1:0] op);
      return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_SLT);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mmes_regfile.sv @@
// 32 x 32 register file, one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero. Uses mmes_pkg.
`default_nettype none

module mmes_regfile (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rd_en,
   input  wire logic [mmes_pkg::REG_IDX_W-1:0]   rd_addr0,
   input  wire logic [mmes_pkg::REG_IDX_W-1:0]   rd_addr1,
   output logic      [mmes_pkg::WORD_W-1:0]      rd_data0,
   output logic      [mmes_pkg::WORD_W-1:0]      rd_data1,
   input  wire logic                             wr_en,
   input  wire logic [mmes_pkg::REG_IDX_W-1:0]   wr_addr,
   input  wire logic [mmes_pkg::WORD_W-1:0]      wr_data
);

   logic [mmes_pkg::WORD_W-1:0]    rf_mem [mmes_pkg::REG_COUNT];
   logic [mmes_pkg::REG_COUNT-1:0] vld_ff;
   logic [mmes_pkg::WORD_W-1:0]    rd0_ff, rd1_ff;
   logic                           v0_ff, v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= rf_mem[rd_addr0];
         rd1_ff <= rf_mem[rd_addr1];
         v0_ff  <= vld_ff[rd_addr0];
         v1_ff  <= vld_ff[rd_addr1];
      end
   end

   assign rd_data0 = v0_ff ? rd0_ff : '0;
   assign rd_data1 = v1_ff ? rd1_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/mmes_dmem.sv @@
// Word data memory, single port, registered read data.
// Fills itself with all ones after reset, one word per cycle. Uses mmes_pkg.
`default_nettype none

module mmes_dmem #(
   parameter int DATA_WORDS = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            acc_en,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(DATA_WORDS)-1:0]   addr,
   input  wire logic [mmes_pkg::WORD_W-1:0]     wr_data,
   output logic      [mmes_pkg::WORD_W-1:0]     rd_data,
   output logic                                 busy
);

   localparam int AddrW = $clog2(DATA_WORDS);
   localparam logic [AddrW-1:0] LastIdx = AddrW'(DATA_WORDS - 1);

   logic [mmes_pkg::WORD_W-1:0] mem [DATA_WORDS];
   logic [mmes_pkg::WORD_W-1:0] rd_data_ff;
   logic [AddrW-1:0]            clr_idx_ff, clr_idx_in;
   logic                        busy_ff;

   assign clr_idx_in = clr_idx_ff + AddrW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         if (clr_idx_ff == LastIdx) begin
            busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= '1;
      end else if (acc_en && wr_en) begin
         mem[addr] <= wr_data;
      end else if (acc_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

@@ rtl/core/mmes_exec.sv @@
// Execute logic: ALU, branch/jump target, load/store address and range check.
// Purely combinational; uses mmes_pkg.
`default_nettype none

module mmes_exec #(
   parameter int DATA_WORDS = 4096
) (
   input  wire mmes_pkg::req_item_type            item,
   input  wire logic [mmes_pkg::PC_W-1:0]         pc,
   input  wire logic [mmes_pkg::WORD_W-1:0]       opnd_s,   // second_reg value
   input  wire logic [mmes_pkg::WORD_W-1:0]       opnd_o,   // first_reg or third_reg value
   output mmes_pkg::exec_ctl_type                 ctl,
   output logic      [$clog2(DATA_WORDS)-1:0]     mem_addr
);

   localparam int AddrW = $clog2(DATA_WORDS);
   localparam int SumW  = mmes_pkg::WORD_W + 2;
   localparam logic signed [SumW-1:0] Limit = SumW'(DATA_WORDS);

   logic [mmes_pkg::PC_W-1:0] pc_step;
   logic signed [SumW-1:0]    addr_sum;
   logic                      aerr;

   assign pc_step  = pc + mmes_pkg::PC_W'(4);
   assign addr_sum = $signed({{2{opnd_s[mmes_pkg::WORD_W-1]}}, opnd_s})
                   + $signed({{(SumW - mmes_pkg::PC_W){1'b0}}, item.immediate});
   assign aerr     = addr_sum[SumW-1] || (addr_sum >= Limit);
   assign mem_addr = addr_sum[AddrW-1:0];

   always_comb begin
      ctl                   = '0;
      ctl.res.next_pc       = pc_step;
      unique case (item.operation) inside
         mmes_pkg::OP_ADD: begin
            ctl.res.write_enable = 1'b1;
            ctl.res.write_value  = opnd_s + opnd_o;
         end
         mmes_pkg::OP_SUB: begin
            ctl.res.write_enable = 1'b1;
            ctl.res.write_value  = opnd_s - opnd_o;
         end
         mmes_pkg::OP_MUL: begin
            ctl.res.write_enable = 1'b1;
            ctl.res.write_value  = opnd_s * opnd_o;
         end
         mmes_pkg::OP_SLT: begin
            ctl.res.write_enable = 1'b1;
            ctl.res.write_value  = {31'b0, $signed(opnd_s) < $signed(opnd_o)};
         end
         mmes_pkg::OP_ADDI: begin
            ctl.res.write_enable = 1'b1;
            ctl.res.write_value  = opnd_s
                                 + {{(mmes_pkg::WORD_W - mmes_pkg::PC_W){1'b0}}, item.immediate};
         end
         mmes_pkg::OP_BEQ: begin
            if (opnd_o == opnd_s) ctl.res.next_pc = item.immediate;
         end
         mmes_pkg::OP_BNE: begin
            if (opnd_o != opnd_s) ctl.res.next_pc = item.immediate;
         end
         mmes_pkg::OP_J: begin
            ctl.res.next_pc = item.immediate;
         end
         mmes_pkg::OP_LW, mmes_pkg::OP_SW: begin
            ctl.res.address_error = aerr;
            if (!aerr) begin
               if (item.operation == mmes_pkg::OP_LW) begin
                  ctl.mem_rd           = 1'b1;
                  ctl.res.write_enable = 1'b1;
               end else begin
                  ctl.mem_wr = 1'b1;
               end
            end
         end
         default: begin
            // halt and the unused codes
            ctl.res.halted  = 1'b1;
            ctl.res.next_pc = pc;
         end
      endcase
      if (ctl.res.write_enable) begin
         ctl.res.write_index = item.first_reg;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mini_mips_execute_step.sv @@
// Top level of the mini MIPS execute step: handshakes, pipeline and forwarding.
// Uses mmes_pkg, mmes_regfile, mmes_dmem, mmes_exec and the assertion header.
`default_nettype none

// Executes one decoded instruction of an eleven-op MIPS subset per request,
// against its own 32-entry register file, a DATA_WORDS-deep word data memory
// and a word program counter that steps by four. Throughput is one request per
// clock while responses are taken. The operands are read at the edge that takes
// a request; the instruction executes in stage 1, and at the edge where stage 1
// moves on the data memory is accessed and the result register loads. Register
// values written by the two requests still in flight are forwarded, so
// back-to-back dependent instructions, including a load followed by its use,
// run at full rate. After reset the data memory is filled with all ones, one
// word per cycle, and req_tready stays low until the fill is done. Halt and the
// unused opcodes report halted and keep the counter; they do not latch.
module mini_mips_execute_step #(
   parameter int DATA_WORDS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: [3:0] operation, [8:4] first_reg, [13:9] second_reg,
   //          [18:14] third_reg, [39:19] immediate
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mmes_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: [20:0] next_pc, [21] write_enable, [26:22] write_index,
   //           [58:27] write_value, [59] halted, [60] address_error, rest zero
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [mmes_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int AddrW = $clog2(DATA_WORDS);

   mmes_pkg::req_item_type   req_item;
   logic                     req_acc;

   // stage 1: register operands are read, instruction executes here
   logic                     s1_vld_ff, s1_vld_in;
   mmes_pkg::req_item_type   s1_item_ff;
   logic                     s1_adv;

   // stage 2: result register, load data comes from the memory read register
   logic                     s2_vld_ff, s2_vld_in;
   mmes_pkg::rsp_result_type s2_res_ff;
   logic                     s2_load_ff;
   logic                     s2_free;
   logic                     rsp_acc;

   // program counter and most recent committed register write
   logic [mmes_pkg::PC_W-1:0]      pc_ff;
   logic                           lw_vld_ff;
   logic [mmes_pkg::REG_IDX_W-1:0] lw_idx_ff;
   logic [mmes_pkg::WORD_W-1:0]    lw_val_ff;

   logic [mmes_pkg::WORD_W-1:0]    rf_rd0, rf_rd1;
   logic [mmes_pkg::WORD_W-1:0]    opnd_s, opnd_o;
   logic [mmes_pkg::REG_IDX_W-1:0] s1_idx_s, s1_idx_o;
   logic [mmes_pkg::WORD_W-1:0]    s2_wval;
   mmes_pkg::rsp_result_type       out_res;

   mmes_pkg::exec_ctl_type   ex_ctl;
   logic [AddrW-1:0]         ex_addr;
   logic [mmes_pkg::WORD_W-1:0] dm_rdata;
   logic                     dm_busy;

   assign req_item = req_tdata;

   // ---- handshakes ----
   assign s2_free    = !s2_vld_ff || rsp_tready;
   assign s1_adv     = s1_vld_ff && s2_free;
   assign req_tready = (!s1_vld_ff || s2_free) && !dm_busy;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = s2_vld_ff && rsp_tready;

   assign s1_vld_in  = req_acc || (s1_vld_ff && !s1_adv);
   assign s2_vld_in  = s1_adv || (s2_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         pc_ff     <= '0;
         lw_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         if (s1_adv) begin
            pc_ff <= ex_ctl.res.next_pc;
         end
         if (rsp_acc && s2_res_ff.write_enable) begin
            lw_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         s2_res_ff  <= ex_ctl.res;
         s2_load_ff <= ex_ctl.mem_rd;
      end
      if (rsp_acc && s2_res_ff.write_enable) begin
         lw_idx_ff <= s2_res_ff.write_index;
         lw_val_ff <= s2_wval;
      end
   end

   // ---- register file: port 0 reads second_reg, port 1 first or third ----
   mmes_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr0 (req_item.second_reg),
      .rd_addr1 (mmes_pkg::uses_third(req_item.operation) ? req_item.third_reg
                                                          : req_item.first_reg),
      .rd_data0 (rf_rd0),
      .rd_data1 (rf_rd1),
      .wr_en    (rsp_acc && s2_res_ff.write_enable),
      .wr_addr  (s2_res_ff.write_index),
      .wr_data  (s2_wval)
   );

   // ---- forwarding ----
   // Priority: the result still in stage 2, then the most recent committed
   // register write, then the register file itself.
   assign s2_wval  = s2_load_ff ? dm_rdata : s2_res_ff.write_value;
   assign s1_idx_s = s1_item_ff.second_reg;
   assign s1_idx_o = mmes_pkg::uses_third(s1_item_ff.operation) ? s1_item_ff.third_reg
                                                                : s1_item_ff.first_reg;

   always_comb begin
      if (s2_vld_ff && s2_res_ff.write_enable && s2_res_ff.write_index == s1_idx_s) begin
         opnd_s = s2_wval;
      end else if (lw_vld_ff && lw_idx_ff == s1_idx_s) begin
         opnd_s = lw_val_ff;
      end else begin
         opnd_s = rf_rd0;
      end
      if (s2_vld_ff && s2_res_ff.write_enable && s2_res_ff.write_index == s1_idx_o) begin
         opnd_o = s2_wval;
      end else if (lw_vld_ff && lw_idx_ff == s1_idx_o) begin
         opnd_o = lw_val_ff;
      end else begin
         opnd_o = rf_rd1;
      end
   end

   // ---- execute ----
   mmes_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
      .item     (s1_item_ff),
      .pc       (pc_ff),
      .opnd_s   (opnd_s),
      .opnd_o   (opnd_o),
      .ctl      (ex_ctl),
      .mem_addr (ex_addr)
   );

   // ---- data memory: stores write and loads read as stage 1 moves on ----
   mmes_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .acc_en  (s1_adv && (ex_ctl.mem_rd || ex_ctl.mem_wr)),
      .wr_en   (ex_ctl.mem_wr),
      .addr    (ex_addr),
      .wr_data (opnd_o),
      .rd_data (dm_rdata),
      .busy    (dm_busy)
   );

   // ---- response ----
   always_comb begin
      out_res             = s2_res_ff;
      out_res.write_value = s2_wval;
   end

   assign rsp_tvalid = s2_vld_ff;
   assign rsp_tdata  = {{mmes_pkg::RSP_PAD_W{1'b0}}, out_res};

   // ---- checks ----
`include "mini_mips_execute_step_assert.svh"

   `MMES_ASSERT_NOW(a_no_req_while_fill, dm_busy, !req_tready, "request taken during memory fill")
   `MMES_ASSERT_NOW(a_halt_no_write, s2_vld_ff && s2_res_ff.halted,
                    !s2_res_ff.write_enable && !s2_res_ff.address_error, "halt with side effect")
   `MMES_ASSERT_NOW(a_load_ok, s2_vld_ff && s2_load_ff,
                    s2_res_ff.write_enable && !s2_res_ff.address_error, "bad load result")
   `MMES_ASSERT_NEXT(a_halt_keeps_pc, s1_adv && ex_ctl.res.halted, $stable(pc_ff),
                     "halt moved the counter")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for mini_mips_execute_step: streams decoded instructions in,
// predicts each result from a shadow register file, data memory and counter.
// Depends on mmes_pkg and the mini_mips_execute_step RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int MEM_WORDS = 4096;
   // top of the opcode space; decodes like halt
   localparam logic [mmes_pkg::OP_W-1:0] OP_RESERVED_LAST = 4'd15;
   localparam logic [mmes_pkg::PC_W-1:0] IMM_MAX = 21'h1FFFFF;
   localparam int RANDOM_TARGET = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mmes_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mmes_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // shadow architectural state
   logic [mmes_pkg::WORD_W-1:0] regs_q [mmes_pkg::REG_COUNT];
   logic [mmes_pkg::WORD_W-1:0] dmem_q [MEM_WORDS];
   logic [mmes_pkg::PC_W-1:0]   pc_q;

   mmes_pkg::req_item_type   program_queue[$];   // instructions not yet offered
   mmes_pkg::rsp_result_type outcomes_due[$];    // predicted results, oldest first

   int total_requests = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int mismatch_count = 0;
   int load_hits = 0, store_hits = 0, range_faults = 0, halt_count = 0, taken_count = 0;

   logic rsp_holdoff  = 1'b0;
   logic holdoff_done = 1'b0;
   int   holdoff_left = 0;

   // calm windows: no random idling on that side
   wire req_steady = (accepted_count >= 500) && (accepted_count < 700);
   wire rsp_steady = (result_count >= 500) && (result_count < 700);

   mini_mips_execute_step #(.DATA_WORDS(MEM_WORDS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // op, first_reg, second_reg, third_reg, immediate
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // next_pc, write_enable/index/value, halted, addr error
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Instruction execution, mirrored on the shadow state.
   // ---------------------------------------------------------------------
   function automatic void clear_processor_state();
      for (int i = 0; i < mmes_pkg::REG_COUNT; i++) regs_q[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) dmem_q[i] = '1;   // unwritten reads as ones
      pc_q = '0;
   endfunction

   function automatic mmes_pkg::rsp_result_type step_processor(mmes_pkg::req_item_type ins);
      mmes_pkg::rsp_result_type    res;
      logic [mmes_pkg::WORD_W-1:0] va, vb, vc;
      logic [mmes_pkg::PC_W-1:0]   next;
      longint                      addr;
      va   = regs_q[ins.first_reg];
      vb   = regs_q[ins.second_reg];
      vc   = regs_q[ins.third_reg];
      next = pc_q + 21'd4;                  // wraps at 2^21
      res  = '0;
      case (ins.operation)
         mmes_pkg::OP_ADD, mmes_pkg::OP_SUB, mmes_pkg::OP_MUL, mmes_pkg::OP_SLT,
         mmes_pkg::OP_ADDI: begin
            res.write_enable = 1'b1;
            res.write_index  = ins.first_reg;
            case (ins.operation)
               mmes_pkg::OP_ADD: res.write_value = vb + vc;
               mmes_pkg::OP_SUB: res.write_value = vb - vc;
               mmes_pkg::OP_MUL: res.write_value = vb * vc;
               mmes_pkg::OP_SLT:
                  res.write_value = ($signed(vb) < $signed(vc)) ? 32'd1 : 32'd0;
               default: res.write_value = vb + {11'b0, ins.immediate};  // zero-extended
            endcase
         end
         mmes_pkg::OP_BEQ: if (va == vb) begin
            next = ins.immediate;
            taken_count++;
         end
         mmes_pkg::OP_BNE: if (va != vb) begin
            next = ins.immediate;
            taken_count++;
         end
         mmes_pkg::OP_J: begin
            next = ins.immediate;
            taken_count++;
         end
         mmes_pkg::OP_LW, mmes_pkg::OP_SW: begin
            // signed base plus unsigned word offset
            addr = longint'($signed(vb)) + longint'(ins.immediate);
            if (addr < 0 || addr >= MEM_WORDS) begin
               res.address_error = 1'b1;
               range_faults++;
            end else if (ins.operation == mmes_pkg::OP_LW) begin
               res.write_enable = 1'b1;
               res.write_index  = ins.first_reg;
               res.write_value  = dmem_q[int'(addr)];
               load_hits++;
            end else begin
               dmem_q[int'(addr)] = va;
               store_hits++;
            end
         end
         default: begin                     // halt and unused codes hold the counter
            res.halted = 1'b1;
            next = pc_q;
            halt_count++;
         end
      endcase
      if (res.write_enable) regs_q[res.write_index] = res.write_value;
      pc_q = next;
      res.next_pc = next;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic queue_instr(logic [mmes_pkg::OP_W-1:0] op, int ra, int rb, int rc, int imm);
      mmes_pkg::req_item_type it;
      it.operation  = op;
      it.first_reg  = ra[mmes_pkg::REG_IDX_W-1:0];
      it.second_reg = rb[mmes_pkg::REG_IDX_W-1:0];
      it.third_reg  = rc[mmes_pkg::REG_IDX_W-1:0];
      it.immediate  = imm[mmes_pkg::PC_W-1:0];
      program_queue.insert(program_queue.size(), it);
   endtask

   // Edge cases first; comments track the register contents.
   task automatic build_directed();
      queue_instr(mmes_pkg::OP_ADDI, 1, 0, 0, IMM_MAX);        // r1 = 0x1fffff
      queue_instr(mmes_pkg::OP_ADDI, 2, 1, 31, IMM_MAX);       // r2 = 0x3ffffe
      queue_instr(mmes_pkg::OP_MUL,  3, 2, 2, 0);              // product wraps
      queue_instr(mmes_pkg::OP_SUB,  4, 0, 1, 0);              // r4 = -0x1fffff
      queue_instr(mmes_pkg::OP_ADD,  5, 4, 4, 0);
      queue_instr(mmes_pkg::OP_SLT,  6, 4, 1, 0);              // signed: 1
      queue_instr(mmes_pkg::OP_SLT,  7, 1, 4, 0);              // signed: 0
      queue_instr(mmes_pkg::OP_ADDI, 0, 0, 0, 5);              // r0 is writable, r0 = 5
      queue_instr(mmes_pkg::OP_BEQ,  1, 1, 0, 100);            // taken
      queue_instr(mmes_pkg::OP_BEQ,  1, 2, 0, 200);            // not taken
      queue_instr(mmes_pkg::OP_BNE,  1, 2, 0, 300);            // taken
      queue_instr(mmes_pkg::OP_BNE,  3, 3, 0, 0);              // not taken
      queue_instr(mmes_pkg::OP_J,    31, 31, 31, IMM_MAX);     // counter at its top
      queue_instr(mmes_pkg::OP_LW,   8, 0, 0, 10);             // counter wraps; unwritten
      queue_instr(mmes_pkg::OP_SW,   1, 0, 0, 10);
      queue_instr(mmes_pkg::OP_LW,   9, 0, 0, 10);             // reads r1 back
      queue_instr(mmes_pkg::OP_LW,   10, 4, 0, 0);             // negative address
      queue_instr(mmes_pkg::OP_LW,   10, 0, 0, MEM_WORDS - 5); // one past the end
      queue_instr(mmes_pkg::OP_SW,   2, 0, 0, MEM_WORDS - 6);  // last word
      queue_instr(mmes_pkg::OP_LW,   11, 0, 0, MEM_WORDS - 6);
      queue_instr(mmes_pkg::OP_SW,   2, 4, 0, IMM_MAX);        // negative base, address 0
      queue_instr(mmes_pkg::OP_LW,   12, 4, 0, IMM_MAX);
      queue_instr(mmes_pkg::OP_SW,   3, 4, 0, 0);              // store out of range
      queue_instr(mmes_pkg::OP_HALT, 0, 0, 0, 0);
      queue_instr(OP_RESERVED_LAST, 31, 31, 31, IMM_MAX);
      queue_instr(mmes_pkg::OP_ADD,  13, 1, 2, 0);             // halt does not latch
   endtask

   task automatic build_random(int target);
      int kind, n, base_reg, scratch, tmp_reg, data_reg, k, off_base, off, pick;
      logic [mmes_pkg::OP_W-1:0] op;
      while (program_queue.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            // noise: every field, every code
            queue_instr(4'($urandom_range(0, 15)), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
         end else if (kind < 60) begin
            // memory run: zero a base register, point it, then loads and stores
            base_reg = $urandom_range(0, 31);
            scratch  = $urandom_range(0, 31);
            queue_instr(mmes_pkg::OP_SUB, base_reg, scratch, scratch, 0);
            if ($urandom_range(0, 3) == 0) begin
               k = $urandom_range(1, 300);
               tmp_reg = (base_reg + 1) % mmes_pkg::REG_COUNT;
               queue_instr(mmes_pkg::OP_ADDI, tmp_reg, base_reg, 0, k);
               queue_instr(mmes_pkg::OP_SUB, base_reg, base_reg, tmp_reg, 0);   // base = -k
               off_base = k;
            end else begin
               k = ($urandom_range(0, 4) == 0) ? $urandom_range(MEM_WORDS - 64, MEM_WORDS - 1)
                                                : $urandom_range(0, 63);
               queue_instr(mmes_pkg::OP_ADDI, base_reg, base_reg, 0, k);
               off_base = 0;
            end
            n = $urandom_range(2, 8);
            repeat (n) begin
               op = $urandom_range(0, 1) ? mmes_pkg::OP_LW : mmes_pkg::OP_SW;
               data_reg = $urandom_range(0, 31);
               if (op == mmes_pkg::OP_LW && data_reg == base_reg)
                  data_reg = (data_reg + 3) % mmes_pkg::REG_COUNT;
               pick = $urandom_range(0, 15);
               if (pick == 0)
                  off = $urandom;                        // almost always out of range
               else if (pick == 1 && off_base > 0)
                  off = off_base - 1;                    // address -1
               else
                  off = off_base + $urandom_range(0, 40);
               queue_instr(op, data_reg, base_reg, $urandom_range(0, 31), off);
            end
         end else if (kind < 85) begin
            // arithmetic chain, mostly on a few registers so results feed each other
            n = $urandom_range(3, 8);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0: op = mmes_pkg::OP_ADD;
                  1: op = mmes_pkg::OP_SUB;
                  2: op = mmes_pkg::OP_MUL;
                  3: op = mmes_pkg::OP_SLT;
                  default: op = mmes_pkg::OP_ADDI;
               endcase
               pick = ($urandom_range(0, 4) == 0) ? 31 : 7;
               queue_instr(op, $urandom_range(0, pick), $urandom_range(0, pick),
                           $urandom_range(0, pick),
                           $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255));
            end
         end else begin
            // control flow
            n = $urandom_range(1, 3);
            repeat (n) begin
               case ($urandom_range(0, 2))
                  0: op = mmes_pkg::OP_BEQ;
                  1: op = mmes_pkg::OP_BNE;
                  default: op = mmes_pkg::OP_J;
               endcase
               base_reg = $urandom_range(0, 31);
               scratch  = $urandom_range(0, 1) ? base_reg : $urandom_range(0, 31);
               queue_instr(op, base_reg, scratch, $urandom_range(0, 31), $urandom);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: one offer at a time, random gaps between requests.
   // Prediction happens at the edge where the request is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            outcomes_due.insert(outcomes_due.size(),
                                step_processor(mmes_pkg::req_item_type'(req_tdata)));
            accepted_count <= accepted_count + 1;
            busy = 1'b0;
         end
         // valid only changes once per edge: held, re-armed with the next item, or dropped
         if (!busy) begin
            if (program_queue.size() != 0 && (req_steady || $urandom_range(0, 99) >= 36)) begin
               req_tdata  <= program_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic void flag_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR result %0d: %s", result_count, msg);
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got)
         flag_failure($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
   endfunction

   always @(posedge clock) begin : rsp_monitor
      mmes_pkg::rsp_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = mmes_pkg::rsp_result_type'(rsp_tdata[$bits(mmes_pkg::rsp_result_type)-1:0]);
            result_count <= result_count + 1;
            if (outcomes_due.size() == 0) begin
               flag_failure("result with no request outstanding");
            end else begin
               want = outcomes_due.pop_front();
               check_field("next_pc",       want.next_pc,       got.next_pc);
               check_field("write_enable",  want.write_enable,  got.write_enable);
               check_field("write_index",   want.write_index,   got.write_index);
               check_field("write_value",   want.write_value,   got.write_value);
               check_field("halted",        want.halted,        got.halted);
               check_field("address_error", want.address_error, got.address_error);
               check_field("pad bits", '0,
                  rsp_tdata[mmes_pkg::RSP_TDATA_W-1:$bits(mmes_pkg::rsp_result_type)]);
            end
         end
         rsp_tready <= !rsp_holdoff && (rsp_steady || $urandom_range(0, 99) >= 36);
      end
   end

   // Backpressure burst: once enough results have drained, refuse results for a
   // long stretch so the pipeline fills and req_tready drops while requests wait.
   always @(posedge clock) begin
      if (reset) begin
         rsp_holdoff  <= 1'b0;
         holdoff_done <= 1'b0;
         holdoff_left <= 0;
      end else if (!holdoff_done && result_count >= 250) begin
         rsp_holdoff  <= 1'b1;
         holdoff_done <= 1'b1;
         holdoff_left <= 300;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_holdoff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing. After reset the block clears its data memory, with req_tready
   // low, before the first request goes in.
   // ---------------------------------------------------------------------
   initial begin
      clear_processor_state();
      build_directed();
      build_random(RANDOM_TARGET);
      total_requests = program_queue.size();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_requests) @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);   // covers the two pipeline stages plus margin for stray results
      $display("Ran %0d instructions: %0d loads, %0d stores, %0d out-of-range accesses,",
               total_requests, load_hits, store_hits, range_faults);
      $display("%0d halts, %0d taken jumps/branches; %0d results checked, %0d mismatches.",
               halt_count, taken_count, result_count, mismatch_count);
      if (mismatch_count == 0 && outcomes_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #200000;
      $display("TIMEOUT: %0d of %0d requests taken, %0d results pending",
               accepted_count, total_requests, outcomes_due.size());
      $display("tb_top failed");
      $finish;
   end

endmodule
